### src/butterworth_lowpass_iir_defines.svh
// Assertion helpers used by the filter top level.
`ifndef BUTTERWORTH_LOWPASS_IIR_DEFINES_SVH
`define BUTTERWORTH_LOWPASS_IIR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BWLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BWLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bwlp_pkg.sv
package bwlp_pkg;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEF       = 4;
  localparam int SAMPLE_BITS_DEF    = 12;
  localparam int COEF_FRAC_BITS_DEF = 30;

  // Fixed field widths
  localparam int CHAN_W    = 2;
  localparam int ORDER_W   = 2;
  localparam int COEF_W    = 32;
  localparam int HIST_W    = 32;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [ORDER_W-1:0] ORDER_FIRST  = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_SECOND = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER = 2'd0,
    REG_B0    = 2'd1,
    REG_A1    = 2'd2,
    REG_A2    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ORDER_W-1:0]       order;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_cfg_t;

endpackage

### src/butterworth_lowpass_iir.sv
// Multi-channel Butterworth low-pass IIR (first or second order, selected by
// the order register; unused codes run second order). Each input transaction
// carries a channel and an unsigned sample and yields one output transaction
// with the rounded, 16-bit saturated result; samples for channels at or above
// CHANNELS are taken and dropped with no result and no history change.
// Coefficients are signed Q(32-COEF_FRAC_BITS).COEF_FRAC_BITS, output history
// is kept per channel in Q16.16. Write the configuration registers only while
// the filter is idle. A sample passes the queue, operand, product and result
// registers in turn. Throughput is one sample per clock while the output is not
// stalled and consecutive samples go to different channels; a sample for the
// channel held in the operand stage waits until the new y1 can be forwarded as
// it retires from the product-and-sum stage. There is no post-reset clearing pass.
`include "butterworth_lowpass_iir_defines.svh"

module butterworth_lowpass_iir #(
  parameter int CHANNELS       = bwlp_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS    = bwlp_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bwlp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bwlp_pkg::CHAN_W-1:0]         in_channel,
  input  logic [SAMPLE_BITS-1:0]              in_sample_value,
  // filtered output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bwlp_pkg::CHAN_W-1:0]         out_channel,
  output logic signed [bwlp_pkg::OUT_W-1:0]   out_filtered_value,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bwlp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bwlp_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  bwlp_pkg::coef_cfg_t    cfg_r;
  logic                   q_valid;
  logic                   q_ready;
  logic [IDX_W-1:0]       q_channel;
  logic [SAMPLE_BITS-1:0] q_sample;

  // Register file: always ready, one register per transaction.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.order <= bwlp_pkg::ORDER_SECOND;
      cfg_r.b0    <= '0;
      cfg_r.a1    <= '0;
      cfg_r.a2    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bwlp_pkg::cfg_reg_t'(cfg_index))
        bwlp_pkg::REG_ORDER: cfg_r.order <= cfg_data[bwlp_pkg::ORDER_W-1:0];
        bwlp_pkg::REG_B0:    cfg_r.b0    <= cfg_data;
        bwlp_pkg::REG_A1:    cfg_r.a1    <= cfg_data;
        bwlp_pkg::REG_A2:    cfg_r.a2    <= cfg_data;
        default:             cfg_r       <= cfg_r;
      endcase
    end
  end

  // Front end: takes samples, drops bad channels, queues the rest.
  bwlp_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_sample_value (in_sample_value),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_channel       (q_channel),
    .q_sample        (q_sample)
  );

  // Back end: history, multiply, sum, round, saturate, output register.
  bwlp_back #(
    .CHANNELS       (CHANNELS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_channel          (q_channel),
    .q_sample           (q_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel        (out_channel),
    .out_filtered_value (out_filtered_value)
  );

  // Only in-range channels reach the back end.
  `BWLP_ASSERT_IMP(a_queue_chan_range, q_valid, 32'(q_channel) < CHANNELS, "queued channel out of range")

  // A kept sample leaves the queue non-empty on the next cycle.
  `BWLP_ASSERT_NXT(a_push_visible, in_valid && in_ready && (32'(in_channel) < CHANNELS), q_valid, "kept sample not queued")

  // Results only for configured channels.
  `BWLP_ASSERT_IMP(a_out_chan_range, out_valid, 32'(out_channel) < CHANNELS, "result channel out of range")

endmodule

### src/bwlp_front.sv
module bwlp_front #(
  parameter int CHANNELS    = bwlp_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = bwlp_pkg::SAMPLE_BITS_DEF,
  localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bwlp_pkg::CHAN_W-1:0]  in_channel,
  input  logic [SAMPLE_BITS-1:0]       in_sample_value,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic [IDX_W-1:0]             q_channel,
  output logic [SAMPLE_BITS-1:0]       q_sample
);

  // two-entry queue toward the arithmetic back end
  logic [IDX_W-1:0]       ch_mem_r [2];
  logic [SAMPLE_BITS-1:0] x_mem_r  [2];
  logic                   wr_ptr_r;
  logic                   rd_ptr_r;
  logic [1:0]             count_r;
  logic                   push;
  logic                   pop;

  assign in_ready  = (count_r != 2'd2);
  // channels outside the configured range are taken and dropped
  assign push      = in_valid && in_ready && (32'(in_channel) < CHANNELS);
  assign q_valid   = (count_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_channel = ch_mem_r[rd_ptr_r];
  assign q_sample  = x_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ch_mem_r[wr_ptr_r] <= IDX_W'(in_channel);
      x_mem_r[wr_ptr_r]  <= in_sample_value;
    end
  end

endmodule

### src/bwlp_back.sv
module bwlp_back #(
  parameter int CHANNELS       = bwlp_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS    = bwlp_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bwlp_pkg::COEF_FRAC_BITS_DEF,
  localparam int IDX_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bwlp_pkg::coef_cfg_t               cfg,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  logic [IDX_W-1:0]                  q_channel,
  input  logic [SAMPLE_BITS-1:0]            q_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bwlp_pkg::CHAN_W-1:0]       out_channel,
  output logic signed [bwlp_pkg::OUT_W-1:0] out_filtered_value
);

  localparam int CW    = bwlp_pkg::COEF_W;
  localparam int HW    = bwlp_pkg::HIST_W;
  localparam int XS_W  = SAMPLE_BITS + 2;
  localparam int P1_W  = CW + HW;
  localparam int P0_W  = CW + XS_W + 1;
  localparam int FB_W  = P1_W - 16;
  localparam int ACC_W = ((P0_W > FB_W) ? P0_W : FB_W) + 2;
  localparam int W2    = ACC_W + 2;
  localparam int SHR   = (COEF_FRAC_BITS >= 16) ? COEF_FRAC_BITS - 16 : 0;
  localparam int SHL   = (COEF_FRAC_BITS < 16) ? 16 - COEF_FRAC_BITS : 0;
  localparam logic [W2-1:0] RND_U = ({{(W2-1){1'b0}}, 1'b1} << SHR) >> 1;

  // per-channel history
  logic [SAMPLE_BITS-1:0] ih1_r [CHANNELS];
  logic [SAMPLE_BITS-1:0] ih2_r [CHANNELS];
  logic signed [HW-1:0]   oh1_r [CHANNELS];
  logic signed [HW-1:0]   oh2_r [CHANNELS];

  // operand stage
  logic                   s1_v_r;
  logic [IDX_W-1:0]       s1_ch_r;
  logic signed [CW-1:0]   s1_a1_r;
  logic signed [HW-1:0]   s1_y1_r;
  logic signed [CW-1:0]   s1_a2_r;
  logic signed [HW-1:0]   s1_y2_r;
  logic signed [CW-1:0]   s1_b0_r;
  logic [XS_W-1:0]        s1_xs_r;

  // product stage
  logic                   s2_v_r;
  logic [IDX_W-1:0]       s2_ch_r;
  logic signed [P1_W-1:0] s2_p1_r;
  logic signed [P1_W-1:0] s2_p2_r;
  logic signed [P0_W-1:0] s2_p0_r;

  // result register
  logic                              out_v_r;
  logic [bwlp_pkg::CHAN_W-1:0]       out_ch_r;
  logic signed [bwlp_pkg::OUT_W-1:0] out_val_r;

  logic                   out_free, s2_free, s1_free;
  logic                   s2_adv, s1_adv, issue;
  logic                   haz_s1, haz_s2, fwd;
  logic                   first_order;
  logic [XS_W-1:0]        xs;
  logic signed [HW-1:0]   y1_rd;
  logic signed [ACC_W-1:0] acc;
  logic signed [W2-1:0]   ext, y_w;
  logic                   y_ovf;
  logic signed [HW-1:0]   y_sat;
  logic signed [HW:0]     r_sum;
  logic signed [16:0]     r17;
  logic signed [bwlp_pkg::OUT_W-1:0] r_sat;

  // handshake through the stages
  assign out_free = !out_v_r || out_ready;
  assign s2_adv   = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_adv   = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;

  // same channel in operand stage: y1 not ready yet
  assign haz_s1  = s1_v_r && (s1_ch_r == q_channel);
  // same channel in product stage: forwarded only if it retires now
  assign fwd     = s2_v_r && (s2_ch_r == q_channel);
  assign haz_s2  = fwd && !out_free;
  assign q_ready = s1_free && !haz_s1 && !haz_s2;
  assign issue   = q_valid && q_ready;

  assign first_order = (cfg.order == bwlp_pkg::ORDER_FIRST);
  assign y1_rd       = fwd ? y_sat : oh1_r[q_channel];

  always_comb begin
    if (first_order) begin
      xs = XS_W'(q_sample) + XS_W'(ih1_r[q_channel]);
    end else begin
      xs = XS_W'(q_sample) + (XS_W'(ih1_r[q_channel]) << 1) + XS_W'(ih2_r[q_channel]);
    end
  end

  // sum in Q.F, convert to Q16.16 with round half up, saturate, then round and saturate to 16 bits
  always_comb begin
    acc   = ACC_W'(s2_p1_r >>> 16) + ACC_W'(s2_p2_r >>> 16) + ACC_W'(s2_p0_r);
    ext   = W2'(acc);
    y_w   = ((ext + $signed(RND_U)) >>> SHR) <<< SHL;
    y_ovf = !((&y_w[W2-1:HW-1]) || !(|y_w[W2-1:HW-1]));
    if (y_ovf) begin
      y_sat = y_w[W2-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
    end else begin
      y_sat = y_w[HW-1:0];
    end
    r_sum = {y_sat[HW-1], y_sat} + (HW+1)'(33'sh8000);
    r17   = r_sum[HW:16];
    if (r17[16] != r17[15]) begin
      r_sat = r17[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r_sat = r17[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ih1_r[i] <= '0;
        ih2_r[i] <= '0;
        oh1_r[i] <= '0;
        oh2_r[i] <= '0;
      end
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (issue) begin
        ih2_r[q_channel] <= ih1_r[q_channel];
        ih1_r[q_channel] <= q_sample;
        oh2_r[q_channel] <= y1_rd;
      end
      if (s2_adv) begin
        oh1_r[s2_ch_r] <= y_sat;
      end
      if (issue) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ch_r <= q_channel;
      s1_a1_r <= cfg.a1;
      s1_y1_r <= y1_rd;
      s1_a2_r <= first_order ? '0 : cfg.a2;
      s1_y2_r <= oh2_r[q_channel];
      s1_b0_r <= cfg.b0;
      s1_xs_r <= xs;
    end
    if (s1_adv) begin
      s2_ch_r <= s1_ch_r;
      s2_p1_r <= s1_a1_r * s1_y1_r;
      s2_p2_r <= s1_a2_r * s1_y2_r;
      s2_p0_r <= P0_W'(s1_b0_r) * $signed({1'b0, s1_xs_r});
    end
    if (s2_adv) begin
      out_ch_r  <= bwlp_pkg::CHAN_W'(s2_ch_r);
      out_val_r <= r_sat;
    end
  end

  assign out_valid          = out_v_r;
  assign out_channel        = out_ch_r;
  assign out_filtered_value = out_val_r;

endmodule
